// ----- rtl/core/stt_pkg.sv -----
package stt_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int IDENT_BITS = 64;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int SLOT_OUT_W = 7;
	localparam int KIND_W     = 3;
	localparam int ID_IN_W    = 64;

	localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = SLOT_OUT_W'(NUM_SLOTS);

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR   = 3'd0,
		KIND_TRACK   = 3'd1,
		KIND_REMOVE  = 3'd2,
		KIND_ITERATE = 3'd3,
		KIND_FIND    = 3'd4
	} kind_t;

	typedef struct packed {
		logic              any;
		logic [SLOT_W-1:0] idx;
	} enc_res_t;

endpackage

// ----- rtl/core/stt_id_ram.sv -----
module stt_id_ram (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [stt_pkg::SLOT_W-1:0]            wr_addr,
	input  logic [stt_pkg::IDENT_BITS-1:0]        wr_data,
	input  logic                                  rd_en,
	input  logic [stt_pkg::SLOT_W-1:0]            rd_addr,
	output logic [stt_pkg::IDENT_BITS-1:0]        rd_data
);

	logic [stt_pkg::IDENT_BITS-1:0] mem [stt_pkg::NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/stt_top_enc.sv -----
module stt_top_enc (
	input  logic [stt_pkg::NUM_SLOTS-1:0] vec,
	output stt_pkg::enc_res_t             res
);

	always_comb begin
		res.any = |vec;
		res.idx = '0;
		for (int i = 0; i < stt_pkg::NUM_SLOTS; i++) begin
			if (vec[i]) begin
				res.idx = stt_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

// ----- rtl/core/slot_tracker_table.sv -----
// Slot tracker table: 64 identifier slots with a free bitmap.
// The input channel (in_valid, in_stall) carries one command per transaction:
// kind, ident and slot_id. The output channel (out_valid, out_stall) returns
// exactly one transaction per command with slot and ok.
// One command is in flight at a time; in_stall is high while a command is
// being worked on. Clear, track and iterate-and-clear update the table on
// acceptance and go straight to ST_DONE, which moves the result into the
// output register; a next command is taken only after ST_DONE is left. Remove
// needs one identifier memory read, compared in ST_CHK before ST_DONE. Find
// walks the occupied slots from the highest down in ST_FIND, one memory read
// per cycle with the compare overlapped, until a match or no slot is left,
// and then goes to ST_DONE; a find with no match returns SLOT_NONE.
// Reset makes every slot free and makes every stored identifier read as zero;
// no clearing pass is needed. While the receiver stalls, a finished result
// waits in the output register and the block holds the next result back
// until that register is taken, so nothing is lost or repeated.
module slot_tracker_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [stt_pkg::KIND_W-1:0]         kind,
	input  logic [stt_pkg::ID_IN_W-1:0]        ident,
	input  logic [stt_pkg::SLOT_OUT_W-1:0]     slot_id,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [stt_pkg::SLOT_OUT_W-1:0]     slot,
	output logic                               ok
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_FIND,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [stt_pkg::NUM_SLOTS-1:0]       free_q;
	logic [stt_pkg::NUM_SLOTS-1:0]       vld_q;
	logic [stt_pkg::NUM_SLOTS-1:0]       busy_q;
	logic                                pend_s1;
	logic [stt_pkg::SLOT_OUT_W-1:0]      res_slot_q;
	logic                                res_ok_q;
	logic                                out_valid_q;
	logic [stt_pkg::SLOT_OUT_W-1:0]      slot_q;
	logic                                ok_q;

	logic [stt_pkg::IDENT_BITS-1:0]      ident_q;
	logic                                sid_ok_q;
	logic [stt_pkg::SLOT_W-1:0]          addr_s1;
	logic                                rd_vld_s1;

	logic                                in_acc;
	logic [stt_pkg::NUM_SLOTS-1:0]       enc_vec;
	stt_pkg::enc_res_t                   enc;
	logic                                wr_en;
	logic                                rd_en;
	logic [stt_pkg::SLOT_W-1:0]          rd_addr;
	logic [stt_pkg::IDENT_BITS-1:0]      rd_data;
	logic [stt_pkg::IDENT_BITS-1:0]      rd_word;
	logic                                rd_match;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign ok        = ok_q;

	assign rd_word  = rd_vld_s1 ? rd_data : '0;
	assign rd_match = (rd_word == ident_q);

	always_comb begin
		if (state_q == ST_FIND) begin
			enc_vec = busy_q;
		end else if (kind == stt_pkg::KIND_TRACK) begin
			enc_vec = free_q;
		end else begin
			enc_vec = ~free_q;
		end
	end

	stt_top_enc u_enc (
		.vec (enc_vec),
		.res (enc)
	);

	always_comb begin
		wr_en   = in_acc && (kind == stt_pkg::KIND_TRACK) && enc.any;
		rd_en   = 1'b0;
		rd_addr = enc.idx;
		if (in_acc && (kind == stt_pkg::KIND_REMOVE)) begin
			rd_en   = 1'b1;
			rd_addr = slot_id[stt_pkg::SLOT_W-1:0];
		end else if (state_q == ST_FIND && !(pend_s1 && rd_match) && enc.any) begin
			rd_en = 1'b1;
		end
	end

	stt_id_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (enc.idx),
		.wr_data (ident[stt_pkg::IDENT_BITS-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ident_q  <= ident[stt_pkg::IDENT_BITS-1:0];
			sid_ok_q <= (slot_id < stt_pkg::SLOT_NONE);
		end
		if (rd_en) begin
			addr_s1   <= rd_addr;
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= '1;
			vld_q       <= '0;
			busy_q      <= '0;
			pend_s1     <= 1'b0;
			res_slot_q  <= stt_pkg::SLOT_NONE;
			res_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q      <= stt_pkg::SLOT_NONE;
			ok_q        <= 1'b0;
		end else begin
			if (!out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_slot_q <= stt_pkg::SLOT_NONE;
						res_ok_q   <= 1'b0;
						state_q    <= ST_DONE;
						case (kind)
							stt_pkg::KIND_CLEAR: begin
								free_q <= '1;
							end
							stt_pkg::KIND_TRACK: begin
								if (enc.any) begin
									free_q[enc.idx] <= 1'b0;
									vld_q[enc.idx]  <= 1'b1;
									res_slot_q      <= stt_pkg::SLOT_OUT_W'(enc.idx);
								end
							end
							stt_pkg::KIND_REMOVE: begin
								state_q <= ST_CHK;
							end
							stt_pkg::KIND_ITERATE: begin
								if (enc.any) begin
									free_q[enc.idx] <= 1'b1;
									res_slot_q      <= stt_pkg::SLOT_OUT_W'(enc.idx);
								end
							end
							stt_pkg::KIND_FIND: begin
								busy_q  <= ~free_q;
								pend_s1 <= 1'b0;
								state_q <= ST_FIND;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHK: begin
					if (sid_ok_q && rd_match) begin
						free_q[addr_s1] <= 1'b1;
						res_ok_q        <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_FIND: begin
					if (pend_s1 && rd_match) begin
						res_slot_q <= stt_pkg::SLOT_OUT_W'(addr_s1);
						pend_s1    <= 1'b0;
						state_q    <= ST_DONE;
					end else if (enc.any) begin
						busy_q[enc.idx] <= 1'b0;
						pend_s1         <= 1'b1;
					end else if (!pend_s1) begin
						state_q <= ST_DONE;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						slot_q      <= res_slot_q;
						ok_q        <= res_ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished command");

	a_busy_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> ((busy_q & free_q) == '0))
		else $error("search candidate is a free slot");

	a_track_claims: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (vld_q[$past(enc.idx)] && !free_q[$past(enc.idx)]))
		else $error("tracked slot not marked occupied");

	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> !wr_en)
		else $error("memory write during search");

endmodule

// ----- test/slot_tracker_table_test.sv -----
module slot_tracker_table_test;

	typedef struct packed {
		logic [stt_pkg::KIND_W-1:0]     kind;
		logic [stt_pkg::ID_IN_W-1:0]    ident;
		logic [stt_pkg::SLOT_OUT_W-1:0] slot_id;
	} cmd_t;

	typedef struct packed {
		logic [stt_pkg::SLOT_OUT_W-1:0] slot;
		logic                           ok;
	} reply_t;

	localparam logic [stt_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [stt_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
	localparam logic [stt_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 2000;
	localparam int PRESSURE_AT  = 300;
	localparam int STALL_HOLD   = 500;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_REPORTS  = 10;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [stt_pkg::KIND_W-1:0]     kind = '0;
	logic [stt_pkg::ID_IN_W-1:0]    ident = '0;
	logic [stt_pkg::SLOT_OUT_W-1:0] slot_id = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [stt_pkg::SLOT_OUT_W-1:0] slot;
	logic                           ok;

	cmd_t   cmd_q[$];
	reply_t slot_results_due[$];

	logic [stt_pkg::NUM_SLOTS-1:0]  shadow_free;
	logic [stt_pkg::IDENT_BITS-1:0] shadow_ids[stt_pkg::NUM_SLOTS];
	logic [stt_pkg::ID_IN_W-1:0]    ident_pool[6];

	cmd_t   live_cmd;
	reply_t due_reply;
	reply_t got_reply;
	int     gap_left = 0;
	int     stall_left = 0;
	int     hold_left = 0;
	logic   pressure_done = 1'b0;
	logic   quiet = 1'b0;
	logic [7:0] quiet_cnt = '0;
	int     idle_cycles = 0;

	int errors = 0;
	int cmds_taken = 0;
	int replies_seen = 0;
	int kind_hist[8];
	int full_tracks = 0;
	int find_hits = 0;
	int removes_ok = 0;

	slot_tracker_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.ident     (ident),
		.slot_id   (slot_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.slot      (slot),
		.ok        (ok)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [stt_pkg::ID_IN_W-1:0] pick_ident();
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		return ident_pool[$urandom_range(0, 5)];
	endfunction

	function automatic logic [stt_pkg::SLOT_OUT_W-1:0] pick_slot_id();
		if ($urandom_range(0, 9) == 0)
			return stt_pkg::SLOT_OUT_W'($urandom_range(stt_pkg::NUM_SLOTS, 127));
		return stt_pkg::SLOT_OUT_W'($urandom_range(0, stt_pkg::NUM_SLOTS - 1));
	endfunction

	task automatic queue_cmd(input logic [stt_pkg::KIND_W-1:0] k,
			input logic [stt_pkg::ID_IN_W-1:0] id,
			input logic [stt_pkg::SLOT_OUT_W-1:0] sid);
		cmd_t c;
		c.kind = k;
		c.ident = id;
		c.slot_id = sid;
		cmd_q.push_back(c);
	endtask

	// Updates the shadow table for one command and returns the reply it must produce.
	task automatic predict_reply(input cmd_t c, output reply_t r);
		int   s;
		logic found;
		r.slot = stt_pkg::SLOT_NONE;
		r.ok = 1'b0;
		found = 1'b0;
		case (c.kind)
			stt_pkg::KIND_CLEAR: begin
				shadow_free = '1;
			end
			stt_pkg::KIND_TRACK: begin
				for (s = stt_pkg::NUM_SLOTS - 1; s >= 0 && !found; s--) begin
					if (shadow_free[s]) begin
						shadow_free[s] = 1'b0;
						shadow_ids[s] = c.ident[stt_pkg::IDENT_BITS-1:0];
						r.slot = stt_pkg::SLOT_OUT_W'(s);
						found = 1'b1;
					end
				end
			end
			stt_pkg::KIND_REMOVE: begin
				if (c.slot_id < stt_pkg::NUM_SLOTS &&
						shadow_ids[c.slot_id[stt_pkg::SLOT_W-1:0]] ==
						c.ident[stt_pkg::IDENT_BITS-1:0]) begin
					shadow_free[c.slot_id[stt_pkg::SLOT_W-1:0]] = 1'b1;
					r.ok = 1'b1;
				end
			end
			stt_pkg::KIND_ITERATE: begin
				for (s = stt_pkg::NUM_SLOTS - 1; s >= 0 && !found; s--) begin
					if (!shadow_free[s]) begin
						shadow_free[s] = 1'b1;
						r.slot = stt_pkg::SLOT_OUT_W'(s);
						found = 1'b1;
					end
				end
			end
			stt_pkg::KIND_FIND: begin
				for (s = stt_pkg::NUM_SLOTS - 1; s >= 0 && !found; s--) begin
					if (!shadow_free[s] &&
							shadow_ids[s] == c.ident[stt_pkg::IDENT_BITS-1:0]) begin
						r.slot = stt_pkg::SLOT_OUT_W'(s);
						found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		quiet_cnt <= quiet_cnt + 8'd1;
		if (quiet_cnt == '0)
			quiet <= ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			ident <= '0;
			slot_id <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_reply(live_cmd, due_reply);
				slot_results_due.push_back(due_reply);
				cmds_taken++;
				kind_hist[live_cmd.kind]++;
				if (live_cmd.kind == stt_pkg::KIND_TRACK &&
						due_reply.slot == stt_pkg::SLOT_NONE)
					full_tracks++;
				if (live_cmd.kind == stt_pkg::KIND_FIND &&
						due_reply.slot != stt_pkg::SLOT_NONE)
					find_hits++;
				if (due_reply.ok)
					removes_ok++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					live_cmd = cmd_q.pop_front();
					kind <= live_cmd.kind;
					ident <= live_cmd.ident;
					slot_id <= live_cmd.slot_id;
					in_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (slot_results_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected reply: slot=%0d ok=%0b", slot, ok);
				end else begin
					due_reply = slot_results_due.pop_front();
					got_reply.slot = slot;
					got_reply.ok = ok;
					if (got_reply !== due_reply) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch on reply %0d: %s slot=%0d ok=%0b, %s slot=%0d ok=%0b",
								replies_seen, "expected", due_reply.slot, due_reply.ok,
								"got", slot, ok);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!pressure_done && replies_seen >= PRESSURE_AT) begin
				pressure_done <= 1'b1;
				hold_left <= STALL_HOLD;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == IDLE_LIMIT) begin
					$display("no transaction for %0d cycles", IDLE_LIMIT);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int total;
		int len;
		int r;
		int i;
		logic [stt_pkg::KIND_W-1:0] k;

		shadow_free = '1;
		for (i = 0; i < stt_pkg::NUM_SLOTS; i++)
			shadow_ids[i] = '0;
		for (i = 0; i < 8; i++)
			kind_hist[i] = 0;
		ident_pool[0] = '0;
		ident_pool[1] = '1;
		ident_pool[2] = {32{2'b01}};
		ident_pool[3] = {32{2'b10}};
		ident_pool[4] = {$urandom, $urandom};
		ident_pool[5] = {$urandom, $urandom};

		queue_cmd(stt_pkg::KIND_FIND, '0, '0);
		queue_cmd(stt_pkg::KIND_ITERATE, '1, '1);
		queue_cmd(stt_pkg::KIND_REMOVE, '0, '0);
		queue_cmd(stt_pkg::KIND_REMOVE, '0, stt_pkg::SLOT_OUT_W'(stt_pkg::NUM_SLOTS));
		queue_cmd(stt_pkg::KIND_REMOVE, '1, '1);
		queue_cmd(stt_pkg::KIND_TRACK, '1, '0);
		queue_cmd(stt_pkg::KIND_TRACK, '0, '1);
		queue_cmd(stt_pkg::KIND_TRACK, ident_pool[2], '0);
		queue_cmd(stt_pkg::KIND_FIND, '1, '0);
		queue_cmd(stt_pkg::KIND_FIND, '0, '0);
		queue_cmd(stt_pkg::KIND_FIND, ident_pool[3], '0);
		queue_cmd(stt_pkg::KIND_REMOVE, ident_pool[2],
			stt_pkg::SLOT_OUT_W'(stt_pkg::NUM_SLOTS - 1));
		queue_cmd(stt_pkg::KIND_REMOVE, '1, stt_pkg::SLOT_OUT_W'(stt_pkg::NUM_SLOTS - 1));
		queue_cmd(stt_pkg::KIND_REMOVE, '1, stt_pkg::SLOT_OUT_W'(stt_pkg::NUM_SLOTS - 1));
		queue_cmd(stt_pkg::KIND_ITERATE, '0, '0);
		queue_cmd(stt_pkg::KIND_ITERATE, '0, '0);
		queue_cmd(stt_pkg::KIND_ITERATE, '0, '0);
		queue_cmd(KIND_SPARE_FIRST, '1, '1);
		queue_cmd(KIND_SPARE_MID, {$urandom, $urandom},
			stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
		queue_cmd(KIND_SPARE_LAST, '0, '0);
		queue_cmd(stt_pkg::KIND_TRACK, ident_pool[4], '0);
		queue_cmd(stt_pkg::KIND_CLEAR, '1, '1);
		queue_cmd(stt_pkg::KIND_FIND, ident_pool[4], '0);

		// Random part: bursts of the same command with occasional fills and drains of
		// the whole table, plus noise commands with fully random fields.
		total = cmd_q.size() + RANDOM_ITEMS;
		while (cmd_q.size() < total) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				len = ($urandom_range(0, 9) == 0) ?
					$urandom_range(stt_pkg::NUM_SLOTS, stt_pkg::NUM_SLOTS + 6)
					: $urandom_range(1, 8);
				for (i = 0; i < len; i++)
					queue_cmd(stt_pkg::KIND_TRACK, pick_ident(),
						stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
			end else if (r < 45) begin
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++)
					queue_cmd(stt_pkg::KIND_REMOVE, pick_ident(), pick_slot_id());
			end else if (r < 65) begin
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++)
					queue_cmd(stt_pkg::KIND_FIND, pick_ident(),
						stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
			end else if (r < 80) begin
				len = ($urandom_range(0, 9) == 0) ?
					$urandom_range(stt_pkg::NUM_SLOTS, stt_pkg::NUM_SLOTS + 6)
					: $urandom_range(1, 8);
				for (i = 0; i < len; i++)
					queue_cmd(stt_pkg::KIND_ITERATE, pick_ident(),
						stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
			end else if (r < 84) begin
				queue_cmd(stt_pkg::KIND_CLEAR, pick_ident(),
					stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
			end else begin
				k = stt_pkg::KIND_W'($urandom_range(0, 7));
				queue_cmd(k, {$urandom, $urandom}, stt_pkg::SLOT_OUT_W'($urandom_range(0, 127)));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() != 0 || in_valid || slot_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d commands: clear %0d, track %0d, remove %0d, iterate %0d, find %0d",
			cmds_taken, kind_hist[stt_pkg::KIND_CLEAR], kind_hist[stt_pkg::KIND_TRACK],
			kind_hist[stt_pkg::KIND_REMOVE], kind_hist[stt_pkg::KIND_ITERATE],
			kind_hist[stt_pkg::KIND_FIND]);
		$display("%0d spare kinds, %0d replies checked, %0d tracks on a full table, %s",
			kind_hist[KIND_SPARE_FIRST] + kind_hist[KIND_SPARE_MID] +
			kind_hist[KIND_SPARE_LAST], replies_seen, full_tracks,
			$sformatf("%0d find hits, %0d removes ok", find_hits, removes_ok));
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
